// File: design/vgm_pkg.sv
// vgm_pkg: shared widths, register indexes, reset values, display types and
// constant-table functions for the vacuum gauge monitor.
// No dependencies.
`default_nettype none

package vgm_pkg;

  // Field widths
  localparam int SIG_W      = 10;
  localparam int UNIT_W     = 2;
  localparam int EXP_W      = 6;
  localparam int MANT_W     = 14;
  localparam int SEG_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Log pressure arithmetic (Q16)
  localparam int Q_FRAC       = 16;
  localparam int LG_W         = 23;
  localparam int LOG_FULL_Q16 = 2378403;
  localparam int POW_SHIFT    = 28;

  // Parameter defaults
  localparam int ADC_BITS_DEF        = 10;
  localparam int FRAC_TABLE_BITS_DEF = 8;

  // Register reset values
  localparam logic [UNIT_W-1:0] UNIT_SELECT_RST  = 2'd0;
  localparam logic [SIG_W-1:0]  ID_EXPECTED_RST  = 10'd470;
  localparam logic [SIG_W-1:0]  ID_TOLERANCE_RST = 10'd100;
  localparam logic [SIG_W-1:0]  OPEN_CODE_RST    = 10'd180;
  localparam logic [SIG_W-1:0]  CLOSE_CODE_RST   = 10'd179;
  localparam logic [SIG_W-1:0]  HV_LEVEL_RST     = 10'd400;

  // Segment patterns
  localparam logic [SEG_W-1:0] SEG_POS   = 7'h73;
  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
  localparam logic [SEG_W-1:0] SEG_ERR   = 7'h79;

  // Exponent span that has a digit on the display
  localparam int DIGIT_EXP_MIN = -9;
  localparam int DIGIT_EXP_MAX = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT_SELECT  = 3'd0,
    REG_ID_EXPECTED  = 3'd1,
    REG_ID_TOLERANCE = 3'd2,
    REG_OPEN_CODE    = 3'd3,
    REG_CLOSE_CODE   = 3'd4,
    REG_HV_LEVEL     = 3'd5
  } cfg_reg_t;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_MBAR   = 2'd0,
    UNIT_TORR   = 2'd1,
    UNIT_PASCAL = 2'd2
  } unit_t;

  // Display fields of one result
  typedef struct packed {
    logic [EXP_W-1:0]  exponent;
    logic [MANT_W-1:0] mantissa_x100;
    logic [SEG_W-1:0]  sign_segments;
    logic [SEG_W-1:0]  digit_segments;
  } disp_t;

  // Unit offset of log pressure, Q16; unused code falls back to mbar
  function automatic logic [LG_W-1:0] unit_coef(input logic [UNIT_W-1:0] unit);
    logic [LG_W-1:0] c;
    case (unit_t'(unit))
      UNIT_TORR:   c = 23'd751043;
      UNIT_PASCAL: c = 23'd611647;
      default:     c = 23'd742523;
    endcase
    return c;
  endfunction

  // 10^(2^-(k+1)) in Q28
  function automatic longint unsigned root_q28(input int unsigned k);
    longint unsigned r;
    case (k)
      0:       r = 64'd848867447;
      1:       r = 64'd477353244;
      2:       r = 64'd357964434;
      3:       r = 64'd309984429;
      4:       r = 64'd288462842;
      5:       r = 64'd278269033;
      6:       r = 64'd273308022;
      7:       r = 64'd270860782;
      8:       r = 64'd269645392;
      9:       r = 64'd269039744;
      10:      r = 64'd268737430;
      default: r = 64'd268586401;
    endcase
    return r;
  endfunction

  // Power of ten of a table index, Q28, rounded after each factor.
  // Evaluated at elaboration only.
  function automatic longint unsigned pow10_entry(input int unsigned idx,
                                                  input int unsigned ftb);
    longint unsigned acc;
    acc = 64'd1 << POW_SHIFT;
    for (int unsigned j = 0; j < ftb; j++) begin
      if (((idx >> j) & 1) != 0) begin
        acc = (acc * root_q28(ftb - 1 - j) + (64'd1 << (POW_SHIFT - 1))) >> POW_SHIFT;
      end
    end
    return acc;
  endfunction

  // Mantissa x100 for an index; hi selects the x1000 scale
  function automatic logic [MANT_W-1:0] mant_entry(input int unsigned idx,
                                                   input int unsigned ftb,
                                                   input logic hi);
    longint unsigned p;
    longint unsigned m;
    p = pow10_entry(idx, ftb);
    m = (p * (hi ? 64'd1000 : 64'd100) + (64'd1 << (POW_SHIFT - 1))) >> POW_SHIFT;
    return m[MANT_W-1:0];
  endfunction

  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SEG_ERR;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/vgm_in_if.sv
// vgm_in_if: sample channel (valid/ready plus converter samples).
// Depends on vgm_pkg.
`default_nettype none

interface vgm_in_if;
  logic                      valid;
  logic                      ready;
  logic [vgm_pkg::SIG_W-1:0] signal_code;
  logic [vgm_pkg::SIG_W-1:0] id_code;
  logic [vgm_pkg::SIG_W-1:0] status_code;
  logic                      power_request;

  modport source (output valid, signal_code, id_code, status_code, power_request,
                  input ready);
  modport sink   (input valid, signal_code, id_code, status_code, power_request,
                  output ready);
endinterface

`default_nettype wire

// File: design/vgm_out_if.sv
// vgm_out_if: result channel (valid/ready plus interlock, power, hv, id fault and display fields).
// Depends on vgm_pkg.
`default_nettype none

interface vgm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              interlock_closed;
  logic                              power_on;
  logic                              hv_on;
  logic                              id_fault;
  logic signed [vgm_pkg::EXP_W-1:0]  exponent;
  logic [vgm_pkg::MANT_W-1:0]        mantissa_x100;
  logic [vgm_pkg::SEG_W-1:0]         sign_segments;
  logic [vgm_pkg::SEG_W-1:0]         digit_segments;

  modport source (output valid, interlock_closed, power_on, hv_on, id_fault, exponent,
                         mantissa_x100, sign_segments, digit_segments,
                  input ready);
  modport sink   (input valid, interlock_closed, power_on, hv_on, id_fault, exponent,
                        mantissa_x100, sign_segments, digit_segments,
                  output ready);
endinterface

`default_nettype wire

// File: design/vgm_cfg_if.sv
// vgm_cfg_if: register write channel (valid/ready, index, data).
// Depends on vgm_pkg.
`default_nettype none

interface vgm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vgm_pkg::CFG_IDX_W-1:0]  index;
  logic [vgm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/vacuum_gauge_monitor.sv
// vacuum_gauge_monitor: cold-cathode gauge monitor top level; identity check,
// power control, hysteresis interlock and log-pressure display.
// Depends on vgm_pkg, vgm_in_if, vgm_out_if, vgm_cfg_if, vgm_log_disp.
//
//  channel  | modport | carries
//  ---------+---------+-----------------------------------------------------
//  in_ch    | sink    | signal/id/status samples, power request
//  out_ch   | source  | interlock, power, hv, id fault, exponent, mantissa, segs
//  cfg_ch   | sink    | register index and write data, always ready
//
// One transaction per cycle while the receiver keeps ready high; an accepted
// item passes through the sample register, then the result register, before
// its result can leave.
// The interlock/power state updates as an item moves into the result
// register, so items are processed strictly in order.
// A stalled result holds; the sample register still takes one more item.
// Reset (rst_n low, synchronous): gauge off, interlock open, registers at
// their defaults, both stages empty.
`default_nettype none

module vacuum_gauge_monitor #(
  parameter int ADC_BITS        = vgm_pkg::ADC_BITS_DEF,
  parameter int FRAC_TABLE_BITS = vgm_pkg::FRAC_TABLE_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  vgm_in_if.sink    in_ch,
  vgm_out_if.source out_ch,
  vgm_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [vgm_pkg::UNIT_W-1:0] unit_select_r;
  logic [vgm_pkg::SIG_W-1:0]  id_expected_r;
  logic [vgm_pkg::SIG_W-1:0]  id_tolerance_r;
  logic [vgm_pkg::SIG_W-1:0]  open_code_r;
  logic [vgm_pkg::SIG_W-1:0]  close_code_r;
  logic [vgm_pkg::SIG_W-1:0]  hv_level_r;

  // Sample stage
  logic                       s1_valid_r;
  logic [vgm_pkg::SIG_W-1:0]  s1_signal_r;
  logic [vgm_pkg::SIG_W-1:0]  s1_id_r;
  logic [vgm_pkg::SIG_W-1:0]  s1_status_r;
  logic                       s1_req_r;

  // Gauge state
  logic                       powered_r, powered_nxt;
  logic                       relay_r, relay_nxt;

  // Result stage
  logic                       out_valid_r;
  logic                       hv_r, hv_nxt;
  logic                       fault_r, fault_nxt;
  vgm_pkg::disp_t             disp_r;
  vgm_pkg::disp_t             disp_nxt;

  logic                       s2_load;
  logic                       in_take;
  logic [vgm_pkg::SIG_W-1:0]  id_dev;

  assign s2_load     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Display datapath
  vgm_log_disp #(
    .ADC_BITS        (ADC_BITS),
    .FRAC_TABLE_BITS (FRAC_TABLE_BITS)
  ) u_log_disp (
    .signal_code (s1_signal_r),
    .unit_select (unit_select_r),
    .disp        (disp_nxt)
  );

  // Identity check, power request and interlock hysteresis
  always_comb begin
    id_dev    = (s1_id_r > id_expected_r) ? (s1_id_r - id_expected_r)
                                          : (id_expected_r - s1_id_r);
    fault_nxt = id_dev > id_tolerance_r;
    hv_nxt    = s1_status_r > hv_level_r;
    powered_nxt = powered_r;
    relay_nxt   = relay_r;
    if (fault_nxt) begin
      // bad identity: drop power and open interlock, skip the rest
      powered_nxt = 1'b0;
      relay_nxt   = 1'b0;
    end else begin
      if (s1_req_r) begin
        powered_nxt = 1'b1;
      end
      // opening wins over closing when thresholds overlap;
      // unpowered gauge can only close
      if (powered_nxt && (s1_signal_r > open_code_r)) begin
        relay_nxt = 1'b0;
      end else if (s1_signal_r < close_code_r) begin
        relay_nxt = 1'b1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_select_r  <= vgm_pkg::UNIT_SELECT_RST;
      id_expected_r  <= vgm_pkg::ID_EXPECTED_RST;
      id_tolerance_r <= vgm_pkg::ID_TOLERANCE_RST;
      open_code_r    <= vgm_pkg::OPEN_CODE_RST;
      close_code_r   <= vgm_pkg::CLOSE_CODE_RST;
      hv_level_r     <= vgm_pkg::HV_LEVEL_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (vgm_pkg::cfg_reg_t'(cfg_ch.index))
        vgm_pkg::REG_UNIT_SELECT:  unit_select_r  <= cfg_ch.data[vgm_pkg::UNIT_W-1:0];
        vgm_pkg::REG_ID_EXPECTED:  id_expected_r  <= cfg_ch.data[vgm_pkg::SIG_W-1:0];
        vgm_pkg::REG_ID_TOLERANCE: id_tolerance_r <= cfg_ch.data[vgm_pkg::SIG_W-1:0];
        vgm_pkg::REG_OPEN_CODE:    open_code_r    <= cfg_ch.data[vgm_pkg::SIG_W-1:0];
        vgm_pkg::REG_CLOSE_CODE:   close_code_r   <= cfg_ch.data[vgm_pkg::SIG_W-1:0];
        vgm_pkg::REG_HV_LEVEL:     hv_level_r     <= cfg_ch.data[vgm_pkg::SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage control and gauge state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      powered_r   <= 1'b0;
      relay_r     <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
        powered_r   <= powered_nxt;
        relay_r     <= relay_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_signal_r <= in_ch.signal_code;
      s1_id_r     <= in_ch.id_code;
      s1_status_r <= in_ch.status_code;
      s1_req_r    <= in_ch.power_request;
    end
    if (s2_load) begin
      hv_r    <= hv_nxt;
      fault_r <= fault_nxt;
      disp_r  <= disp_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.interlock_closed = relay_r;
  assign out_ch.power_on         = powered_r;
  assign out_ch.hv_on            = hv_r;
  assign out_ch.id_fault         = fault_r;
  assign out_ch.exponent         = $signed(disp_r.exponent);
  assign out_ch.mantissa_x100    = disp_r.mantissa_x100;
  assign out_ch.sign_segments    = disp_r.sign_segments;
  assign out_ch.digit_segments   = disp_r.digit_segments;

  // Identity fault always leaves the gauge off and the interlock open
  a_fault_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.id_fault |-> !out_ch.power_on && !out_ch.interlock_closed)
    else $error("id fault result with power or interlock active");

  // Interlock opens only on a fault or while powered
  a_open_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(relay_r) |-> $past(s2_load) && ($past(fault_nxt) || $past(powered_nxt)))
    else $error("interlock opened without fault or power");

  // Mantissa x100 stays within 100 to 10000
  a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.mantissa_x100 >= 14'd100 && out_ch.mantissa_x100 <= 14'd10000)
    else $error("mantissa out of range");

  // Gauge state changes only when an item enters the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_load |=> $stable(powered_r) && $stable(relay_r))
    else $error("gauge state changed without a transaction");

endmodule

`default_nettype wire

// File: design/vgm_log_disp.sv
// vgm_log_disp: signal code to log pressure, decimal exponent, mantissa and
// segment patterns. Combinational. Depends on vgm_pkg.
`default_nettype none

module vgm_log_disp #(
  parameter int ADC_BITS        = vgm_pkg::ADC_BITS_DEF,
  parameter int FRAC_TABLE_BITS = vgm_pkg::FRAC_TABLE_BITS_DEF
) (
  input  wire logic [vgm_pkg::SIG_W-1:0]  signal_code,
  input  wire logic [vgm_pkg::UNIT_W-1:0] unit_select,
  output vgm_pkg::disp_t                  disp
);

  localparam longint ADC_MAX   = (64'd1 << ADC_BITS) - 1;
  localparam longint SLOPE     = (vgm_pkg::LOG_FULL_Q16 + ADC_MAX / 2) / ADC_MAX;
  localparam int     SLOPE_W   = $clog2(SLOPE + 1);
  localparam int     CODE_W    = (ADC_BITS < vgm_pkg::SIG_W) ? ADC_BITS : vgm_pkg::SIG_W;
  localparam int     PROD_W    = CODE_W + SLOPE_W;
  localparam int     EXI_W     = vgm_pkg::LG_W - vgm_pkg::Q_FRAC + 1;
  localparam int     TAB_DEPTH = 1 << FRAC_TABLE_BITS;

  logic [CODE_W-1:0]                    code;
  logic [PROD_W-1:0]                    prod;
  logic signed [vgm_pkg::LG_W-1:0]      lg;
  logic [vgm_pkg::Q_FRAC-1:0]           frac;
  logic                                 ip;
  logic signed [EXI_W-1:0]              ex;
  logic [FRAC_TABLE_BITS-1:0]           idx;
  logic [3:0]                           mag;
  logic [vgm_pkg::MANT_W-1:0]           tab_lo [TAB_DEPTH];
  logic [vgm_pkg::MANT_W-1:0]           tab_hi [TAB_DEPTH];

  // Mantissa tables, constant: fractional part below one and at/above one
  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    assign tab_lo[g] = vgm_pkg::mant_entry(g, FRAC_TABLE_BITS, 1'b0);
    assign tab_hi[g] = vgm_pkg::mant_entry(g, FRAC_TABLE_BITS, 1'b1);
  end

  always_comb begin
    // Saturate to converter range
    if (64'(signal_code) > ADC_MAX) begin
      code = CODE_W'(ADC_MAX);
    end else begin
      code = CODE_W'(signal_code);
    end
    prod = PROD_W'(code) * PROD_W'(SLOPE);
    lg   = $signed(vgm_pkg::LG_W'(prod)) - $signed(vgm_pkg::unit_coef(unit_select));
    frac = lg[vgm_pkg::Q_FRAC-1:0];
    // Truncated log minus one: floor, less one more unless a negative
    // value has a fractional part
    ip   = !lg[vgm_pkg::LG_W-1] || (frac == '0);
    ex   = $signed({lg[vgm_pkg::LG_W-1], lg[vgm_pkg::LG_W-1:vgm_pkg::Q_FRAC]})
           - $signed({{(EXI_W-1){1'b0}}, ip});
    idx  = frac[vgm_pkg::Q_FRAC-1 -: FRAC_TABLE_BITS];

    disp.exponent      = ex[vgm_pkg::EXP_W-1:0];
    disp.mantissa_x100 = ip ? tab_hi[idx] : tab_lo[idx];
    disp.sign_segments = (ex >= 0) ? vgm_pkg::SEG_POS : vgm_pkg::SEG_MINUS;

    mag = (ex < 0) ? 4'(-ex) : 4'(ex);
    if (ex >= vgm_pkg::DIGIT_EXP_MIN && ex <= vgm_pkg::DIGIT_EXP_MAX) begin
      disp.digit_segments = vgm_pkg::digit_seg(mag);
    end else begin
      disp.digit_segments = vgm_pkg::SEG_ERR;
    end
  end

endmodule

`default_nettype wire

// File: dv/vgm_reading_checker.sv
`timescale 1ns / 1ps
// vgm_reading_checker: watches the sample, result and register channels of the
// vacuum gauge monitor, predicts every reading and compares results in order.
// Depends on vgm_pkg and the vgm_in_if, vgm_out_if and vgm_cfg_if interfaces.

module vgm_reading_checker
  import vgm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  vgm_in_if    in_ch,
  vgm_out_if   out_ch,
  vgm_cfg_if   cfg_ch,
  output int   reading_errors,
  output int   readings_pending
);

  localparam int              ADC_W      = ADC_BITS_DEF;
  localparam int              FTB        = FRAC_TABLE_BITS_DEF;
  localparam longint          ADC_MAX    = (longint'(1) << ADC_W) - 1;
  localparam longint          SLOPE_Q16  = (LOG_FULL_Q16 + ADC_MAX / 2) / ADC_MAX;
  localparam longint          Q16_ONE    = longint'(1) << Q_FRAC;
  localparam longint unsigned ROUND_HALF = 64'd1 << (POW_SHIFT - 1);
  localparam int              MAX_REPORTS = 10;

  // 10^(2^-k), k = 1..12, Q28
  localparam longint unsigned ROOT_Q28 [12] = '{
    64'd848867447, 64'd477353244, 64'd357964434, 64'd309984429,
    64'd288462842, 64'd278269033, 64'd273308022, 64'd270860782,
    64'd269645392, 64'd269039744, 64'd268737430, 64'd268586401
  };

  localparam logic [SEG_W-1:0] DIGIT_PATTERN [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic                    interlock_closed;
    logic                    power_on;
    logic                    hv_on;
    logic                    id_fault;
    logic signed [EXP_W-1:0] exponent;
    logic [MANT_W-1:0]       mantissa_x100;
    logic [SEG_W-1:0]        sign_segments;
    logic [SEG_W-1:0]        digit_segments;
  } reading_t;

  logic [UNIT_W-1:0] unit_sel   = UNIT_SELECT_RST;
  logic [SIG_W-1:0]  id_exp     = ID_EXPECTED_RST;
  logic [SIG_W-1:0]  id_tol     = ID_TOLERANCE_RST;
  logic [SIG_W-1:0]  open_thr   = OPEN_CODE_RST;
  logic [SIG_W-1:0]  close_thr  = CLOSE_CODE_RST;
  logic [SIG_W-1:0]  hv_thr     = HV_LEVEL_RST;
  bit                gauge_powered = 1'b0;
  bit                relay_closed  = 1'b0;

  reading_t expected_readings [$];
  reading_t want, got;
  int       fail_count = 0;

  function automatic longint unit_offset_q16(input logic [UNIT_W-1:0] u);
    case (u)
      UNIT_TORR:   return 751043;
      UNIT_PASCAL: return 611647;
      default:     return 742523;  // code 3 reads as mbar
    endcase
  endfunction

  // Product of the roots selected by the index bits, rounded after each factor
  function automatic longint unsigned ten_pow_frac(input int unsigned idx);
    longint unsigned acc;
    acc = 64'd1 << POW_SHIFT;
    for (int j = 0; j < FTB; j++) begin
      if (idx[j]) acc = (acc * ROOT_Q28[(FTB - 1 - j) % 12] + ROUND_HALF) >> POW_SHIFT;
    end
    return acc;
  endfunction

  // Advances power/interlock state and returns the reading for one sample
  function automatic reading_t predict_reading(input logic [SIG_W-1:0] sig, idc, st,
                                               input logic req);
    reading_t        r;
    int unsigned     dev;
    bit              fault;
    longint          code, lg, ex, e;
    longint unsigned p, m;
    int unsigned     frac_idx;
    dev   = (idc > id_exp) ? idc - id_exp : id_exp - idc;
    fault = dev > id_tol;
    if (fault) begin
      gauge_powered = 1'b0;
      relay_closed  = 1'b0;
    end else begin
      if (req) gauge_powered = 1'b1;
      if (gauge_powered && sig > open_thr) relay_closed = 1'b0;
      else if (sig < close_thr) relay_closed = 1'b1;
    end

    code = (sig > ADC_MAX) ? ADC_MAX : longint'(sig);
    lg   = code * SLOPE_Q16 - unit_offset_q16(unit_sel);
    ex   = lg / Q16_ONE - 1;               // truncates toward zero
    e    = lg - ex * Q16_ONE;              // in (0, 2) in Q16
    frac_idx = int'(e % Q16_ONE) >> (Q_FRAC - FTB);
    p = ten_pow_frac(frac_idx);
    m = (p * (((e / Q16_ONE) != 0) ? 64'd1000 : 64'd100) + ROUND_HALF) >> POW_SHIFT;

    r.interlock_closed = relay_closed;
    r.power_on         = gauge_powered;
    r.hv_on            = st > hv_thr;
    r.id_fault         = fault;
    r.exponent         = ex[EXP_W-1:0];
    r.mantissa_x100    = m[MANT_W-1:0];
    r.sign_segments    = (ex >= 0) ? SEG_POS : SEG_MINUS;
    r.digit_segments   = (ex >= DIGIT_EXP_MIN && ex <= DIGIT_EXP_MAX) ?
                         DIGIT_PATTERN[(ex < 0) ? -ex : ex] : SEG_ERR;
    return r;
  endfunction

  function automatic string show(input reading_t r);
    return $sformatf("closed=%0d power=%0d hv=%0d fault=%0d exp=%0d mant=%0d sign=%02h digit=%02h",
                     r.interlock_closed, r.power_on, r.hv_on, r.id_fault,
                     r.exponent, r.mantissa_x100, r.sign_segments, r.digit_segments);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      unit_sel      = UNIT_SELECT_RST;
      id_exp        = ID_EXPECTED_RST;
      id_tol        = ID_TOLERANCE_RST;
      open_thr      = OPEN_CODE_RST;
      close_thr     = CLOSE_CODE_RST;
      hv_thr        = HV_LEVEL_RST;
      gauge_powered = 1'b0;
      relay_closed  = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_UNIT_SELECT:  unit_sel  = cfg_ch.data[UNIT_W-1:0];
          REG_ID_EXPECTED:  id_exp    = cfg_ch.data;
          REG_ID_TOLERANCE: id_tol    = cfg_ch.data;
          REG_OPEN_CODE:    open_thr  = cfg_ch.data;
          REG_CLOSE_CODE:   close_thr = cfg_ch.data;
          REG_HV_LEVEL:     hv_thr    = cfg_ch.data;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready)
        expected_readings.push_back(predict_reading(in_ch.signal_code, in_ch.id_code,
                                                    in_ch.status_code, in_ch.power_request));

      if (out_ch.valid && out_ch.ready) begin
        got.interlock_closed = out_ch.interlock_closed;
        got.power_on         = out_ch.power_on;
        got.hv_on            = out_ch.hv_on;
        got.id_fault         = out_ch.id_fault;
        got.exponent         = out_ch.exponent;
        got.mantissa_x100    = out_ch.mantissa_x100;
        got.sign_segments    = out_ch.sign_segments;
        got.digit_segments   = out_ch.digit_segments;
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%t: unexpected reading: %s", $realtime, show(got));
        end else begin
          want = expected_readings.pop_front();
          if (want.interlock_closed !== got.interlock_closed ||
              want.power_on         !== got.power_on         ||
              want.hv_on            !== got.hv_on            ||
              want.id_fault         !== got.id_fault         ||
              want.exponent         !== got.exponent         ||
              want.mantissa_x100    !== got.mantissa_x100    ||
              want.sign_segments    !== got.sign_segments    ||
              want.digit_segments   !== got.digit_segments) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%t: reading mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
    reading_errors   <= fail_count;
    readings_pending <= expected_readings.size();
  end

endmodule

// File: dv/tb_vacuum_gauge_monitor.sv
`timescale 1ns / 1ps
// tb_vacuum_gauge_monitor: stimulus and verdict for the vacuum gauge monitor;
// a reading checker alongside the block predicts and compares every result.
// Depends on vgm_pkg, the vgm_*_if interfaces, vgm_reading_checker and the RTL.

module tb_vacuum_gauge_monitor;
  import vgm_pkg::*;

  localparam int SIG_MAX         = (1 << SIG_W) - 1;
  localparam int RESET_CYCLES    = 12;
  // a little margin after the last reading before touching registers
  localparam int DRAIN_CYCLES    = 4;
  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT     = 2000;
  localparam int SETUPS_PER_MODE = 6;
  localparam int ITEMS_PER_SETUP = 80;

  // indexes past the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;

  vgm_in_if  in_ch();
  vgm_out_if out_ch();
  vgm_cfg_if cfg_ch();

  int reading_errors;
  int readings_pending;

  // percentage of cycles in which the sender idles / the receiver stalls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // stimulus-side view of the thresholds, used only to aim the samples
  int unsigned cur_id_exp = ID_EXPECTED_RST;
  int unsigned cur_id_tol = ID_TOLERANCE_RST;
  int unsigned cur_open   = OPEN_CODE_RST;
  int unsigned cur_close  = CLOSE_CODE_RST;
  int unsigned cur_hv     = HV_LEVEL_RST;

  int idle_run = 0;

  vacuum_gauge_monitor i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vgm_reading_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_ch           (cfg_ch),
    .reading_errors   (reading_errors),
    .readings_pending (readings_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random back-pressure at the current stall rate
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // One sample transaction; valid is left high, settle() or an idle wait in the next call drops it
  task automatic send_sample(input int unsigned sig, idc, st, input bit req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.signal_code   <= sig[SIG_W-1:0];
    in_ch.id_code       <= idc[SIG_W-1:0];
    in_ch.status_code   <= st[SIG_W-1:0];
    in_ch.power_request <= req;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every reading is back and the pipe is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the whole register map, plus both spare indexes, with the block idle
  task automatic load_registers(input int unsigned unit_data, id_e, id_t, opn, cls, hv);
    logic [CFG_IDX_W-1:0] idx [8];
    int unsigned          val [8];
    idx = '{REG_UNIT_SELECT, REG_ID_EXPECTED, REG_ID_TOLERANCE, REG_OPEN_CODE,
            REG_CLOSE_CODE, REG_HV_LEVEL, REG_SPARE_LO, REG_SPARE_HI};
    val = '{unit_data, id_e, id_t, opn, cls, hv,
            $urandom_range(SIG_MAX), $urandom_range(SIG_MAX)};
    settle();
    for (int k = 0; k < 8; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k][CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_id_exp = id_e;
    cur_id_tol = id_t;
    cur_open   = opn;
    cur_close  = cls;
    cur_hv     = hv;
  endtask

  // A code a few steps either side of a threshold, clamped to the converter range
  function automatic int unsigned near_code(input int unsigned centre);
    int v;
    v = int'(centre) + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > SIG_MAX) v = SIG_MAX;
    return v;
  endfunction

  // Mostly good identities and signals around the hysteresis band, so power
  // comes on and the interlock toggles; the rest is noise, faults included.
  task automatic random_sample();
    int unsigned lo, hi, idc, sig, st;
    lo = (cur_id_exp > cur_id_tol) ? cur_id_exp - cur_id_tol : 0;
    hi = (cur_id_exp + cur_id_tol > SIG_MAX) ? SIG_MAX : cur_id_exp + cur_id_tol;
    if ($urandom_range(99) < 12) idc = $urandom_range(SIG_MAX);
    else idc = $urandom_range(hi, lo);
    case ($urandom_range(2))
      0:       sig = $urandom_range(SIG_MAX);
      1:       sig = near_code(cur_open);
      default: sig = near_code(cur_close);
    endcase
    st = ($urandom_range(1) != 0) ? $urandom_range(SIG_MAX) : near_code(cur_hv);
    send_sample(sig, idc, st, $urandom_range(3) == 0);
  endtask

  initial begin
    int unsigned opn, cls;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.signal_code   <= '0;
    in_ch.id_code       <= '0;
    in_ch.status_code   <= '0;
    in_ch.power_request <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_UNIT_SELECT;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset thresholds (id 470 +/- 100, open 180, close 179, hv 400)
    send_sample(0,    0,    0,    0);  // identity fault, all fields low
    send_sample(1023, 1023, 1023, 1);  // fault wins over the power request
    send_sample(1023, 470,  1023, 1);  // powers on, high signal keeps relay open
    send_sample(100,  470,  400,  0);  // closes; hv exactly at level is off
    send_sample(179,  470,  401,  0);  // inside the band: holds closed
    send_sample(180,  470,  0,    0);  // at the open threshold: still holds
    send_sample(181,  470,  0,    0);  // just above: opens
    send_sample(179,  470,  0,    0);  // holds open
    send_sample(178,  570,  0,    0);  // deviation equal to tolerance is good
    send_sample(500,  571,  0,    1);  // one past tolerance: power off, relay open
    send_sample(1023, 370,  0,    0);  // unpowered, high signal: no change
    send_sample(0,    370,  0,    0);  // unpowered gauge may still close
    send_sample(1023, 470,  0,    0);  // ...but never opens
    send_sample(512,  369,  512,  0);  // fault on the low side

    // thresholds overlapping: open below close, torr
    load_registers(UNIT_TORR, 470, 100, 100, 500, 400);
    send_sample(0,    470, 0,    0);   // lowest exponent, digit out of range
    send_sample(300,  470, 0,    1);   // powered and above open: opens though below close
    send_sample(50,   470, 0,    0);
    send_sample(1023, 470, 1023, 0);

    load_registers(UNIT_PASCAL, ID_EXPECTED_RST, ID_TOLERANCE_RST,
                   OPEN_CODE_RST, CLOSE_CODE_RST, HV_LEVEL_RST);
    send_sample(1023, 470, 0, 0);      // highest exponent
    send_sample(0,    470, 0, 0);

    // unit code 3 (upper data bits set too) falls back to mbar
    load_registers(SIG_MAX, ID_EXPECTED_RST, ID_TOLERANCE_RST,
                   OPEN_CODE_RST, CLOSE_CODE_RST, HV_LEVEL_RST);
    send_sample(0,    470, 0, 0);
    send_sample(1023, 470, 0, 0);
    send_sample(512,  470, 0, 1);

    // ---- random: slow receiver, then slow sender, then both flat out
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 34;
          recv_stall_pct = 79;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 34;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int s = 0; s < SETUPS_PER_MODE; s++) begin
        case (s)
          0: load_registers($urandom_range(SIG_MAX), ID_EXPECTED_RST, ID_TOLERANCE_RST,
                            OPEN_CODE_RST, CLOSE_CODE_RST, HV_LEVEL_RST);
          1: load_registers(0, 0, 0, 0, 0, 0);
          2: load_registers(SIG_MAX, SIG_MAX, SIG_MAX, SIG_MAX, SIG_MAX, SIG_MAX);
          default: begin
            opn = $urandom_range(SIG_MAX);
            // half the time a proper band below open, otherwise anything
            if ($urandom_range(1) != 0) cls = (opn > 20) ? opn - $urandom_range(20) : 0;
            else cls = $urandom_range(SIG_MAX);
            load_registers($urandom_range(SIG_MAX), $urandom_range(SIG_MAX),
                           $urandom_range(150), opn, cls, $urandom_range(SIG_MAX));
          end
        endcase
        for (int n = 0; n < ITEMS_PER_SETUP; n++) random_sample();
      end
    end

    settle();
    if (reading_errors == 0 && readings_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/vgm_pkg.sv
design/vgm_in_if.sv
design/vgm_out_if.sv
design/vgm_cfg_if.sv
design/vgm_log_disp.sv
design/vacuum_gauge_monitor.sv
dv/vgm_reading_checker.sv
dv/tb_vacuum_gauge_monitor.sv
